/* rtl/trl_pkg.sv */
// Shared types, constants and command codes for the rate limiter.
`timescale 1ns / 1ps
package trl_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int LIMIT_WIDTH     = 31;
    localparam int KIND_WIDTH      = 2;
    localparam int APB_ADDR_WIDTH  = 3;
    localparam int APB_DATA_WIDTH  = 32;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_LIMIT = 2'd0,
        KIND_SEED  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    localparam logic [APB_ADDR_WIDTH-1:0] ADDR_SLEW  = 3'd0;
    localparam logic [APB_ADDR_WIDTH-1:0] ADDR_ACCEL = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_PROD,
        ST_SQRT,
        ST_DIV,
        ST_VLIM,
        ST_MOVE,
        ST_MOVE2,
        ST_DONE
    } state_t;

    // Shared unit operation selects
    typedef enum logic [1:0] {
        OP_NONE,
        OP_SQRT,
        OP_DIV
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

/* rtl/trl_iter_unit.sv */
// Shared restoring unit: bit-serial square root and long division, one bit per cycle.
`timescale 1ns / 1ps
module trl_iter_unit #(
    parameter int W = 128,
    parameter int QW = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  trl_pkg::unit_ctl_t   ctl,
    input  logic [W-1:0]         num,
    input  logic [QW-1:0]        den,
    output trl_pkg::unit_sts_t   sts,
    output logic [QW-1:0]        result
);
    import trl_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    op_t            op_reg, op_next;
    logic [W-1:0]   n_reg, n_next;
    logic [QW+1:0]  rem_reg, rem_next;
    logic [QW-1:0]  q_reg, q_next;
    logic [QW-1:0]  d_reg, d_next;
    logic [QW+1:0]  trial;
    logic [QW+1:0]  shifted;

    // Sequence the shared subtract: two numerator bits per step for root, one for divide
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        shifted   = '0;
        trial     = '0;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            op_next   = ctl.op;
            n_next    = num;
            d_next    = den;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = CW'(QW);
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_SQRT)
            begin
                shifted = {rem_reg[QW-1:0], n_reg[W-1 -: 2]};
                n_next  = {n_reg[W-3:0], 2'b00};
                trial   = {q_reg, 2'b01};
            end
            else
            begin
                shifted = {rem_reg[QW:0], n_reg[QW-1]};
                n_next  = {n_reg[W-2:0], 1'b0};
                trial   = {2'b00, d_reg};
            end
            if (shifted >= trial)
            begin
                rem_next = shifted - trial;
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold the iteration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_NONE;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = q_reg;

endmodule

/* rtl/trapezoidal_rate_limiter_top.sv */
// Top level of the slew and acceleration rate limiter with its sequencer and APB registers.
`timescale 1ns / 1ps
// Sequencing: seed, clear and ignored items, an unseeded limit step and a zero-step hold go
//   from ST_ERR straight to ST_DONE; any other limit step passes through ST_PROD, then ST_SQRT
//   or ST_DIV, ST_VLIM, ST_MOVE and ST_MOVE2, using the shared root or divide unit.
// Throughput: one item at a time; ready is low while an item is at work or its result waits.
// The bit-serial root/divide unit produces one quotient or root bit per cycle.
// Reset: rst_n clears the registers, the stored command, velocity and seeded flag at once.
module trapezoidal_rate_limiter_top #(
    parameter int VALUE_WIDTH = trl_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = trl_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [trl_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [trl_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [trl_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [trl_pkg::KIND_WIDTH-1:0]       kind,
    input  logic signed [31:0]                   target_value,
    input  logic signed [31:0]                   seed_velocity,
    input  logic [31:0]                          time_step,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [31:0]                   command_value,
    output logic signed [31:0]                   command_velocity,
    output logic                                 at_target
);
    import trl_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int WW = VW + 2;                 // working width for sums
    localparam int QW = 64;                     // root and quotient width
    localparam int NW = 2 * QW;                 // numerator width of shared unit
    localparam logic signed [WW-1:0] VMAX = WW'((65'sd1 <<< (VW - 1)) - 1);
    localparam logic signed [WW-1:0] VMIN = -VMAX - 1;

    // Configuration registers
    logic [LIMIT_WIDTH-1:0] slew_reg;
    logic [LIMIT_WIDTH-1:0] accel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slew_reg  <= '0;
            accel_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == ADDR_SLEW)
                slew_reg <= pwdata[LIMIT_WIDTH-1:0];
            else if (paddr == ADDR_ACCEL)
                accel_reg <= pwdata[LIMIT_WIDTH-1:0];
        end
    end

    always_comb
    begin
        if (paddr == ADDR_SLEW)
            prdata = {1'b0, slew_reg};
        else if (paddr == ADDR_ACCEL)
            prdata = {1'b0, accel_reg};
        else
            prdata = '0;
    end
    assign pready = 1'b1;

    // Saturate an input to the value range
    function automatic logic signed [WW-1:0] sat_in(input logic signed [31:0] x);
        logic signed [WW-1:0] t;
        t = WW'(signed'(x));
        if (t > VMAX)
            return VMAX;
        if (t < VMIN)
            return VMIN;
        return t;
    endfunction

    function automatic logic signed [WW-1:0] sat_v(input logic signed [WW-1:0] x);
        if (x > VMAX)
            return VMAX;
        if (x < VMIN)
            return VMIN;
        return x;
    endfunction

    // Signed value from a magnitude, saturated
    function automatic logic signed [WW-1:0] sat_mag(input logic [QW-1:0] m, input logic neg);
        if (neg)
        begin
            if (m > QW'(VMAX) + 1'b1)
                return VMIN;
            return -WW'(m);
        end
        if (m > QW'(VMAX))
            return VMAX;
        return WW'(m);
    endfunction

    // State
    state_t state_reg, state_next;
    logic                 seeded_reg, seeded_next;
    logic signed [WW-1:0] cmd_reg, cmd_next;
    logic signed [WW-1:0] vel_reg, vel_next;
    logic signed [WW-1:0] des_reg, des_next;
    logic signed [WW-1:0] sv_reg, sv_next;
    logic [31:0]          dt_reg, dt_next;
    kind_t                kind_reg, kind_next;
    logic signed [WW-1:0] err_reg, err_next;
    logic [QW-1:0]        emag_reg, emag_next;
    logic [NW-1:0]        prod_reg, prod_next;
    logic signed [WW-1:0] v_reg, v_next;
    logic [QW-1:0]        mv_reg, mv_next;
    logic                 at_reg, at_next;
    logic                 ov_reg, ov_next;

    unit_ctl_t     uctl;
    unit_sts_t     usts;
    logic [NW-1:0] unum;
    logic [QW-1:0] uden;
    logic [QW-1:0] ures;

    trl_iter_unit #(.W(NW), .QW(QW)) u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (uctl),
        .num    (unum),
        .den    (uden),
        .sts    (usts),
        .result (ures)
    );

    logic signed [WW-1:0] slew_s;
    logic signed [WW-1:0] dvs;
    logic signed [WW-1:0] vlo, vhi, vt;
    logic [NW-1:0]        dprod;
    logic [QW-1:0]        dmov;
    logic signed [QW:0]   csum;
    logic signed [WW-1:0] cnew;

    assign slew_s = WW'(slew_reg);

    // Sequencer: one step of the limit arithmetic per state
    always_comb
    begin
        state_next  = state_reg;
        seeded_next = seeded_reg;
        cmd_next    = cmd_reg;
        vel_next    = vel_reg;
        des_next    = des_reg;
        sv_next     = sv_reg;
        dt_next     = dt_reg;
        kind_next   = kind_reg;
        err_next    = err_reg;
        emag_next   = emag_reg;
        prod_next   = prod_reg;
        v_next      = v_reg;
        mv_next     = mv_reg;
        at_next     = at_reg;
        ov_next     = ov_reg;
        uctl.start  = 1'b0;
        uctl.op     = OP_NONE;
        unum        = '0;
        uden        = '0;
        dvs         = '0;
        vlo         = '0;
        vhi         = '0;
        vt          = v_reg;
        dprod       = '0;
        dmov        = '0;
        csum        = '0;
        cnew        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    des_next  = sat_in(target_value);
                    sv_next   = sat_in(seed_velocity);
                    dt_next   = time_step;
                    kind_next = kind_t'(kind);
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                at_next = 1'b0;
                err_next  = sat_v(des_reg - cmd_reg);
                emag_next = (des_reg - cmd_reg) < 0 ? QW'(-sat_v(des_reg - cmd_reg))
                                                    : QW'(sat_v(des_reg - cmd_reg));
                state_next = ST_DONE;
                case (kind_reg)
                    KIND_LIMIT:
                    begin
                        if (!seeded_reg)
                        begin
                            cmd_next    = des_reg;
                            vel_next    = '0;
                            seeded_next = 1'b1;
                            at_next     = 1'b1;
                        end
                        else if (dt_reg == '0)
                            at_next = (cmd_reg == des_reg);
                        else
                            state_next = ST_PROD;
                    end
                    KIND_SEED:
                    begin
                        cmd_next    = des_reg;
                        vel_next    = sv_reg;
                        seeded_next = 1'b1;
                        at_next     = 1'b1;
                    end
                    KIND_CLEAR:
                    begin
                        cmd_next    = '0;
                        vel_next    = '0;
                        seeded_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_PROD:
            begin
                // 2*a*|err| for the root, or start the divide
                prod_next = NW'({accel_reg, 1'b0}) * NW'(emag_reg[VW-1:0]);
                if (accel_reg != '0)
                    state_next = ST_SQRT;
                else
                begin
                    uctl.start = 1'b1;
                    uctl.op    = OP_DIV;
                    unum       = NW'(emag_reg) << FRAC_BITS;
                    uden       = QW'(dt_reg);
                    state_next = ST_DIV;
                end
            end
            ST_SQRT:
            begin
                uctl.start = 1'b1;
                uctl.op    = OP_SQRT;
                unum       = prod_reg;
                state_next = ST_VLIM;
            end
            ST_DIV:
            begin
                // A quotient past the range saturates in the magnitude conversion
                if (usts.done)
                begin
                    v_next     = sat_mag(ures, err_reg < 0);
                    state_next = ST_VLIM;
                end
            end
            ST_VLIM:
            begin
                if (!usts.busy && !uctl.start)
                begin
                    if (accel_reg != '0)
                        vt = sat_mag(ures, err_reg < 0);
                    if (slew_reg != '0)
                    begin
                        if (vt > slew_s)
                            vt = slew_s;
                        else if (vt < -slew_s)
                            vt = -slew_s;
                    end
                    if (accel_reg != '0)
                    begin
                        dprod = NW'(accel_reg) * NW'(dt_reg);
                        dvs   = (dprod >> FRAC_BITS) > NW'(VMAX) ? VMAX
                                                                 : WW'(dprod >> FRAC_BITS);
                        vlo = sat_v(vel_reg - dvs);
                        vhi = sat_v(vel_reg + dvs);
                        if (vt < vlo)
                            vt = vlo;
                        else if (vt > vhi)
                            vt = vhi;
                    end
                    v_next  = vt;
                    mv_next = vt < 0 ? QW'(-vt) : QW'(vt);
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                prod_next  = NW'(mv_reg[VW-1:0]) * NW'(dt_reg);
                state_next = ST_MOVE2;
            end
            ST_MOVE2:
            begin
                dmov = QW'(prod_reg >> FRAC_BITS);
                if ((prod_reg >> (QW + FRAC_BITS)) != '0 || dmov > (QW'(1) << 62))
                    dmov = QW'(1) << 62;
                if (v_reg < 0)
                    csum = (QW+1)'(cmd_reg) - (QW+1)'(dmov);
                else
                    csum = (QW+1)'(cmd_reg) + (QW+1)'(dmov);
                if (csum > (QW+1)'(VMAX))
                    cnew = VMAX;
                else if (csum < (QW+1)'(VMIN))
                    cnew = VMIN;
                else
                    cnew = WW'(csum);
                if ((err_reg >= 0 && cnew >= des_reg) || (err_reg <= 0 && cnew <= des_reg))
                begin
                    cmd_next = des_reg;
                    vel_next = '0;
                    at_next  = 1'b1;
                end
                else
                begin
                    cmd_next = cnew;
                    vel_next = v_reg;
                    at_next  = 1'b0;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                ov_next = 1'b1;
                if (ov_reg && out_ready)
                begin
                    ov_next    = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            seeded_reg <= 1'b0;
            cmd_reg    <= '0;
            vel_reg    <= '0;
            ov_reg     <= 1'b0;
            at_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            seeded_reg <= seeded_next;
            cmd_reg    <= cmd_next;
            vel_reg    <= vel_next;
            ov_reg     <= ov_next;
            at_reg     <= at_next;
        end
    end

    // Payload working registers
    always_ff @(posedge clk)
    begin
        des_reg  <= des_next;
        sv_reg   <= sv_next;
        dt_reg   <= dt_next;
        kind_reg <= kind_next;
        err_reg  <= err_next;
        emag_reg <= emag_next;
        prod_reg <= prod_next;
        v_reg    <= v_next;
        mv_reg   <= mv_next;
    end

    assign in_ready         = (state_reg == ST_IDLE);
    assign out_valid        = ov_reg;
    assign command_value    = 32'(cmd_reg);
    assign command_velocity = 32'(vel_reg);
    assign at_target        = at_reg;

endmodule

/* rtl/trl_checker.sv */
// Port-level checker for the rate limiter and its bind.
`timescale 1ns / 1ps
module trl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] command_value,
    input logic        at_target
);
    // One item at a time: no intake while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");

    // A transfer in drops ready next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready held after input transfer");

    // Result holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(command_value)
                                       && $stable(at_target)))
        else $error("result changed while stalled");

    // Result transfer frees the input side
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> (in_ready && !out_valid))
        else $error("block not idle after result transfer");
endmodule

bind trapezoidal_rate_limiter_top trl_checker u_trl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .command_value (command_value),
    .at_target     (at_target)
);
